@@ hw/rtl/nearest_neighbor_image_scaler_unit_assert.svh @@
// Assertion macros used by the checker module.
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_UNIT_ASSERT_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define NNIS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define NNIS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hw/rtl/nnis_pkg.sv @@
package nnis_pkg;

   // Frame store geometry
   localparam int MAX_SRC_WIDTH  = 512;
   localparam int MAX_SRC_HEIGHT = 512;

   // Field and register widths
   localparam int SIZE_W  = 10;
   localparam int DST_W   = 12;
   localparam int COORD_W = 11;
   localparam int PIX_W   = 24;
   localparam int FRAC_W  = 16;

   // Datapath widths
   localparam int RATIO_W = SIZE_W + FRAC_W;
   localparam int PROD_W  = RATIO_W + COORD_W;
   localparam int SUM_W   = PROD_W + 1;
   localparam int SRC_W   = SUM_W - FRAC_W;
   localparam int COL_W   = $clog2(MAX_SRC_WIDTH);
   localparam int ROW_W   = $clog2(MAX_SRC_HEIGHT);
   localparam int DEPTH   = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(RATIO_W + 1);

   // One half in 22.16
   localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_W - 1);

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH,
      CSR_SRC_HEIGHT,
      CSR_DST_WIDTH,
      CSR_DST_HEIGHT
   } csr_index_type;

   localparam logic [SIZE_W-1:0] SRC_SIZE_RESET = SIZE_W'(512);
   localparam logic [DST_W-1:0]  DST_SIZE_RESET = DST_W'(512);

   // Commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // Frame store access, one per cycle unless the pipeline holds
   typedef struct packed {
      logic              wr;
      logic              rd;
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  data;
   } mem_req_type;

   // Source size limited to 1..maxv
   function automatic logic [SIZE_W-1:0] eff_src(logic [SIZE_W-1:0] v, int maxv);
      logic [SIZE_W-1:0] r;
      if (v == '0) r = SIZE_W'(1);
      else if (32'(v) > 32'(maxv)) r = SIZE_W'(maxv);
      else r = v;
      return r;
   endfunction

   // Destination size, zero taken as one
   function automatic logic [DST_W-1:0] eff_dst(logic [DST_W-1:0] v);
      return (v == '0) ? DST_W'(1) : v;
   endfunction

endpackage

@@ hw/rtl/nearest_neighbor_image_scaler_unit.sv @@
// Nearest-neighbor image scaler with a built-in frame store.
// Request channel (req_*): command 0 writes req_pixel_in at source column
// req_coord_x, row req_coord_y; writes outside the store are dropped and give
// no response. Command 1 reads destination pixel (x, y) and returns the
// nearest source pixel on the response channel (rsp_*).
// Configuration (csr_*): source and destination sizes; write only while idle.
// A read transaction passes mapping stages 0 to 3 and the registered store
// read before it shows on rsp_*. Throughput: one transaction per cycle through
// four mapping stages and one store access per cycle on the single frame store
// port, while req_stall is low. After reset and after each configuration write
// the 10.16 ratios are recomputed by bit-serial dividers and req_stall stays
// high until they finish; a write that lands while a recompute is running
// waits for it to finish, and req_stall stays high until its own recompute ends.
// The store itself is not cleared; read only pixels that were written.
// Reset clears the pipeline, sets all size registers to 512.
// When the receiver stalls a pending response, the whole pipeline holds and
// req_stall is raised; the response stays on rsp_* unchanged.
module nearest_neighbor_image_scaler_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [nnis_pkg::COORD_W-1:0]    req_coord_x,
   input  logic [nnis_pkg::COORD_W-1:0]    req_coord_y,
   input  logic [nnis_pkg::PIX_W-1:0]      req_pixel_in,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [nnis_pkg::PIX_W-1:0]      rsp_pixel_out,
   input  logic                            csr_we,
   input  logic [nnis_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [nnis_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import nnis_pkg::*;

   logic [SIZE_W-1:0]  src_width_ff, src_width_in;
   logic [SIZE_W-1:0]  src_height_ff, src_height_in;
   logic [DST_W-1:0]   dst_width_ff, dst_width_in;
   logic [DST_W-1:0]   dst_height_ff, dst_height_in;
   logic               dirty_ff, dirty_in;

   logic [SIZE_W-1:0]  sw_eff, sh_eff;
   logic [RATIO_W-1:0] ratio_x, ratio_y;
   logic               busy_x, busy_y, div_start;
   logic               en, accept;
   mem_req_type        mem_req;

   // Register writes; any write marks the ratios stale
   always_comb begin
      src_width_in  = src_width_ff;
      src_height_in = src_height_ff;
      dst_width_in  = dst_width_ff;
      dst_height_in = dst_height_ff;
      dirty_in      = dirty_ff && !div_start;
      if (csr_we) begin
         dirty_in = 1'b1;
         unique case (csr_index_type'(csr_index))
            CSR_SRC_WIDTH:  src_width_in  = csr_wdata[SIZE_W-1:0];
            CSR_SRC_HEIGHT: src_height_in = csr_wdata[SIZE_W-1:0];
            CSR_DST_WIDTH:  dst_width_in  = csr_wdata[DST_W-1:0];
            CSR_DST_HEIGHT: dst_height_in = csr_wdata[DST_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SRC_SIZE_RESET;
         src_height_ff <= SRC_SIZE_RESET;
         dst_width_ff  <= DST_SIZE_RESET;
         dst_height_ff <= DST_SIZE_RESET;
         dirty_ff      <= 1'b1;
      end else begin
         src_width_ff  <= src_width_in;
         src_height_ff <= src_height_in;
         dst_width_ff  <= dst_width_in;
         dst_height_ff <= dst_height_in;
         dirty_ff      <= dirty_in;
      end
   end

   // Ratio recompute
   assign sw_eff    = eff_src(src_width_ff, MAX_SRC_WIDTH);
   assign sh_eff    = eff_src(src_height_ff, MAX_SRC_HEIGHT);
   assign div_start = dirty_ff && !busy_x && !busy_y;

   nnis_ratio_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sw_eff, FRAC_W'(0)}),
      .divisor  (eff_dst(dst_width_ff)),
      .busy     (busy_x),
      .quotient (ratio_x)
   );

   nnis_ratio_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sh_eff, FRAC_W'(0)}),
      .divisor  (eff_dst(dst_height_ff)),
      .busy     (busy_y),
      .quotient (ratio_y)
   );

   // Flow control: pipeline moves unless a response is held
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en || dirty_ff || busy_x || busy_y;
   assign accept    = req_valid && !req_stall;

   nnis_coord_pipe u_pipe (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .accept   (accept),
      .command  (req_command),
      .coord_x  (req_coord_x),
      .coord_y  (req_coord_y),
      .pixel_in (req_pixel_in),
      .ratio_x  (ratio_x),
      .ratio_y  (ratio_y),
      .src_w    (sw_eff),
      .src_h    (sh_eff),
      .mem_req  (mem_req)
   );

   nnis_frame_mem u_mem (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .mem_req  (mem_req),
      .rd_valid (rsp_valid),
      .rd_data  (rsp_pixel_out)
   );

endmodule

@@ hw/rtl/nnis_ratio_div.sv @@
// Restoring divider, one quotient bit per cycle.
module nnis_ratio_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [nnis_pkg::RATIO_W-1:0]   dividend,
   input  logic [nnis_pkg::DST_W-1:0]     divisor,
   output logic                           busy,
   output logic [nnis_pkg::RATIO_W-1:0]   quotient
);
   import nnis_pkg::*;

   logic                busy_ff, busy_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [RATIO_W-1:0]  dvd_ff, dvd_in;
   logic [RATIO_W-1:0]  quo_ff, quo_in;
   logic [DST_W-1:0]    rem_ff, rem_in;
   logic [DST_W-1:0]    dvs_ff, dvs_in;
   logic [DST_W:0]      trial;
   logic                qbit;

   // One shift-subtract step
   always_comb begin
      trial   = {rem_ff, dvd_ff[RATIO_W-1]};
      qbit    = (trial >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(RATIO_W);
         dvd_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 1;
         quo_in = {quo_ff[RATIO_W-2:0], qbit};
         rem_in = qbit ? DST_W'(trial - {1'b0, dvs_ff}) : trial[DST_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

@@ hw/rtl/nnis_coord_pipe.sv @@
// Coordinate mapping: multiply, round and clamp for reads (writes keep their coordinates), then store address.
module nnis_coord_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          accept,
   input  logic                          command,
   input  logic [nnis_pkg::COORD_W-1:0]  coord_x,
   input  logic [nnis_pkg::COORD_W-1:0]  coord_y,
   input  logic [nnis_pkg::PIX_W-1:0]    pixel_in,
   input  logic [nnis_pkg::RATIO_W-1:0]  ratio_x,
   input  logic [nnis_pkg::RATIO_W-1:0]  ratio_y,
   input  logic [nnis_pkg::SIZE_W-1:0]   src_w,
   input  logic [nnis_pkg::SIZE_W-1:0]   src_h,
   output nnis_pkg::mem_req_type         mem_req
);
   import nnis_pkg::*;

   // Stage 0: captured transaction
   logic                v0_ff;
   logic                cmd0_ff;
   logic [COORD_W-1:0]  x0_ff, y0_ff;
   logic [PIX_W-1:0]    pix0_ff;
   // Stage 1: products
   logic                v1_ff;
   logic                cmd1_ff;
   logic [COORD_W-1:0]  x1_ff, y1_ff;
   logic [PIX_W-1:0]    pix1_ff;
   logic [PROD_W-1:0]   prodx1_ff, prody1_ff, prodx1_in, prody1_in;
   // Stage 2: store coordinates
   logic                wr2_ff, rd2_ff, wr2_in, rd2_in;
   logic [COL_W-1:0]    col2_ff, col2_in;
   logic [ROW_W-1:0]    row2_ff, row2_in;
   logic [PIX_W-1:0]    pix2_ff;
   // Stage 3: store access
   mem_req_type         req3_ff, req3_in;

   logic [SUM_W-1:0]    sumx, sumy;
   logic [SRC_W-1:0]    sx, sy;
   logic [SIZE_W-1:0]   wm1, hm1;
   logic                in_bounds;

   // Ratio times destination coordinate
   assign prodx1_in = PROD_W'(ratio_x) * PROD_W'(x0_ff);
   assign prody1_in = PROD_W'(ratio_y) * PROD_W'(y0_ff);

   // Round to nearest, clamp to last source pixel
   always_comb begin
      sumx = SUM_W'(prodx1_ff) + HALF;
      sumy = SUM_W'(prody1_ff) + HALF;
      sx   = sumx[SUM_W-1:FRAC_W];
      sy   = sumy[SUM_W-1:FRAC_W];
      wm1  = src_w - SIZE_W'(1);
      hm1  = src_h - SIZE_W'(1);
      in_bounds = (32'(x1_ff) < 32'(MAX_SRC_WIDTH)) && (32'(y1_ff) < 32'(MAX_SRC_HEIGHT));
      wr2_in = v1_ff && (cmd1_ff == CMD_WRITE) && in_bounds;
      rd2_in = v1_ff && (cmd1_ff == CMD_READ);
      if (cmd1_ff == CMD_READ) begin
         col2_in = (sx > SRC_W'(wm1)) ? COL_W'(wm1) : COL_W'(sx);
         row2_in = (sy > SRC_W'(hm1)) ? ROW_W'(hm1) : ROW_W'(sy);
      end else begin
         col2_in = COL_W'(x1_ff);
         row2_in = ROW_W'(y1_ff);
      end
   end

   // Row-major address
   always_comb begin
      req3_in.wr   = wr2_ff;
      req3_in.rd   = rd2_ff;
      req3_in.addr = ADDR_W'(row2_ff) * ADDR_W'(MAX_SRC_WIDTH) + ADDR_W'(col2_ff);
      req3_in.data = pix2_ff;
   end

   // Control, cleared on reset; the store request is kept in this one process
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff      <= 1'b0;
         v1_ff      <= 1'b0;
         wr2_ff     <= 1'b0;
         rd2_ff     <= 1'b0;
         req3_ff.wr <= 1'b0;
         req3_ff.rd <= 1'b0;
      end else if (en) begin
         v0_ff        <= accept;
         v1_ff        <= v0_ff;
         wr2_ff       <= wr2_in;
         rd2_ff       <= rd2_in;
         req3_ff.wr   <= req3_in.wr;
         req3_ff.rd   <= req3_in.rd;
         req3_ff.addr <= req3_in.addr;
         req3_ff.data <= req3_in.data;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (en) begin
         if (accept) begin
            cmd0_ff <= command;
            x0_ff   <= coord_x;
            y0_ff   <= coord_y;
            pix0_ff <= pixel_in;
         end
         cmd1_ff      <= cmd0_ff;
         x1_ff        <= x0_ff;
         y1_ff        <= y0_ff;
         pix1_ff      <= pix0_ff;
         prodx1_ff    <= prodx1_in;
         prody1_ff    <= prody1_in;
         col2_ff      <= col2_in;
         row2_ff      <= row2_in;
         pix2_ff      <= pix1_ff;
      end
   end

   assign mem_req = req3_ff;

endmodule

@@ hw/rtl/nnis_frame_mem.sv @@
// Frame store, single port, registered read data.
module nnis_frame_mem (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  nnis_pkg::mem_req_type       mem_req,
   output logic                        rd_valid,
   output logic [nnis_pkg::PIX_W-1:0]  rd_data
);
   import nnis_pkg::*;

   logic [PIX_W-1:0] store [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;
   logic             rd_valid_ff;

   // Accesses are issued in order, one per cycle while en is high: no overlap to resolve
   always_ff @(posedge clock) begin
      if (en && mem_req.wr) store[mem_req.addr] <= mem_req.data;
      if (en && mem_req.rd) rd_data_ff <= store[mem_req.addr];
   end

   // Result valid, held while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (en) begin
         rd_valid_ff <= mem_req.rd;
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_data  = rd_data_ff;

endmodule

@@ hw/rtl/nnis_checker.sv @@
`include "nearest_neighbor_image_scaler_unit_assert.svh"

// Port-level checks of the scaler.
module nnis_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [nnis_pkg::PIX_W-1:0]      rsp_pixel_out,
   input logic                            csr_we
);
   import nnis_pkg::*;

   // Held response stays put
   `NNIS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_pixel_out))

   // No response right out of reset
   `NNIS_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // Ratios are recomputed after reset and after a register write
   `NNIS_ASSERT_NEXT(a_reset_busy, clock, 1'b0, reset, req_stall)
   `NNIS_ASSERT_NEXT(a_cfg_busy, clock, reset, csr_we, req_stall)

   // A held response blocks new requests
   `NNIS_ASSERT_IMPLY(a_backpressure, clock, reset, rsp_valid && rsp_stall, req_stall)

endmodule

bind nearest_neighbor_image_scaler_unit nnis_checker u_nnis_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_pixel_out (rsp_pixel_out),
   .csr_we        (csr_we)
);

@@ bench/nearest_neighbor_image_scaler_unit_test.sv @@
module nearest_neighbor_image_scaler_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import nnis_pkg::*;

   localparam int HOLD_CYCLES   = 200;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 60;
   localparam int COORD_MAX     = (1 << COORD_W) - 1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_command = CMD_WRITE;
   logic [COORD_W-1:0]    req_coord_x = '0;
   logic [COORD_W-1:0]    req_coord_y = '0;
   logic [PIX_W-1:0]      req_pixel_in = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PIX_W-1:0]      rsp_pixel_out;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_SRC_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow of the frame store and the size registers
   logic [PIX_W-1:0]  source_pixels [int unsigned];
   logic [SIZE_W-1:0] src_width_reg  = SRC_SIZE_RESET;
   logic [SIZE_W-1:0] src_height_reg = SRC_SIZE_RESET;
   logic [DST_W-1:0]  dst_width_reg  = DST_SIZE_RESET;
   logic [DST_W-1:0]  dst_height_reg = DST_SIZE_RESET;

   // Pixels still owed by the block, oldest first
   logic [PIX_W-1:0] pending_pixels [$];
   int mismatch_count = 0;

   // Flow control knobs
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_request = 0;
   int hold_seen    = 0;
   int hold_left    = 0;

   nearest_neighbor_image_scaler_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_coord_x   (req_coord_x),
      .req_coord_y   (req_coord_y),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel_out (rsp_pixel_out),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Source size: zero counts as one, anything past the store is cut down
   function automatic int unsigned clip_src(logic [SIZE_W-1:0] v, int unsigned limit);
      if (v == '0) return 1;
      if (32'(v) > limit) return limit;
      return 32'(v);
   endfunction

   // One axis of the nearest-neighbor mapping, 48.16 ratio, rounded, clamped
   function automatic int unsigned nearest_source(int unsigned d, int unsigned src,
                                                  int unsigned dst);
      longint unsigned ratio;
      longint unsigned pos;
      ratio = (64'(src) << FRAC_W) / 64'(dst);
      pos = (ratio * 64'(d) + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
      if (pos > 64'(src - 1)) pos = 64'(src - 1);
      return int'(pos);
   endfunction

   // Store address that a destination pixel maps to under the current sizes
   function automatic int unsigned source_address(logic [COORD_W-1:0] x,
                                                  logic [COORD_W-1:0] y);
      int unsigned sw;
      int unsigned sh;
      int unsigned dw;
      int unsigned dh;
      sw = clip_src(src_width_reg, MAX_SRC_WIDTH);
      sh = clip_src(src_height_reg, MAX_SRC_HEIGHT);
      dw = (dst_width_reg == '0) ? 1 : 32'(dst_width_reg);
      dh = (dst_height_reg == '0) ? 1 : 32'(dst_height_reg);
      return nearest_source(32'(y), sh, dh) * MAX_SRC_WIDTH + nearest_source(32'(x), sw, dw);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_src_size();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return CSR_DATA_W'($urandom_range(513, 4095));
         2:       return CSR_DATA_W'(512);
         3, 4:    return CSR_DATA_W'($urandom_range(1, 512));
         default: return CSR_DATA_W'($urandom_range(1, 24));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_dst_size();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return CSR_DATA_W'(2048);
         2:       return CSR_DATA_W'($urandom_range(2049, 4095));
         3, 4:    return CSR_DATA_W'($urandom_range(1, 2048));
         default: return CSR_DATA_W'($urandom_range(1, 64));
      endcase
   endfunction

   // Offer one transaction, update the shadow store or queue the pixel owed
   task automatic send_transaction(logic command, logic [COORD_W-1:0] x,
                                   logic [COORD_W-1:0] y, logic [PIX_W-1:0] pixel);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= command;
      req_coord_x  <= x;
      req_coord_y  <= y;
      req_pixel_in <= pixel;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (command == CMD_READ)
         pending_pixels.push_back(source_pixels[source_address(x, y)]);
      else if (x < MAX_SRC_WIDTH && y < MAX_SRC_HEIGHT)
         source_pixels[y * MAX_SRC_WIDTH + x] = pixel;
   endtask

   // Read a destination pixel; write its source pixel first if needed or asked
   task automatic read_scaled(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, bit refresh);
      int unsigned addr;
      addr = source_address(x, y);
      if (refresh || !source_pixels.exists(addr))
         send_transaction(CMD_WRITE, COORD_W'(addr % MAX_SRC_WIDTH),
                          COORD_W'(addr / MAX_SRC_WIDTH), PIX_W'($urandom()));
      send_transaction(CMD_READ, x, y, PIX_W'($urandom()));
   endtask

   // Drop valid, wait for all owed pixels, then let writes in flight retire
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_SRC_WIDTH:  src_width_reg  = value[SIZE_W-1:0];
         CSR_SRC_HEIGHT: src_height_reg = value[SIZE_W-1:0];
         CSR_DST_WIDTH:  dst_width_reg  = value[DST_W-1:0];
         CSR_DST_HEIGHT: dst_height_reg = value[DST_W-1:0];
      endcase
   endtask

   task automatic program_sizes(logic [CSR_DATA_W-1:0] sw, logic [CSR_DATA_W-1:0] sh,
                                logic [CSR_DATA_W-1:0] dw, logic [CSR_DATA_W-1:0] dh);
      wait_for_idle();
      write_register(CSR_SRC_WIDTH, sw);
      write_register(CSR_SRC_HEIGHT, sh);
      write_register(CSR_DST_WIDTH, dw);
      write_register(CSR_DST_HEIGHT, dh);
      csr_we <= 1'b0;
   endtask

   task automatic set_idling(int send_pct, int recv_pct);
      sender_idle_pct = send_pct;
      receiver_stall_pct <= recv_pct;
   endtask

   // Mostly write-then-read pairs, some stray writes, some dropped writes
   task automatic run_scaling_phase(int item_goal);
      int done;
      int pick;
      int unsigned lim_x;
      int unsigned lim_y;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      done  = 0;
      lim_x = (dst_width_reg == '0) ? 0 : (dst_width_reg > 2048) ? COORD_MAX : dst_width_reg - 1;
      lim_y = (dst_height_reg == '0) ? 0 : (dst_height_reg > 2048) ? COORD_MAX : dst_height_reg - 1;
      while (done < item_goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            if ($urandom_range(0, 4) == 0) begin
               x = COORD_W'($urandom());
               y = COORD_W'($urandom());
            end else begin
               x = COORD_W'($urandom_range(0, lim_x));
               y = COORD_W'($urandom_range(0, lim_y));
            end
            read_scaled(x, y, 1'($urandom_range(0, 1)));
            done++;
         end else if (pick < 85) begin
            send_transaction(CMD_WRITE, COORD_W'($urandom_range(0, MAX_SRC_WIDTH - 1)),
                             COORD_W'($urandom_range(0, MAX_SRC_HEIGHT - 1)),
                             PIX_W'($urandom()));
            done++;
         end else begin
            // outside the store: dropped by the block
            x = COORD_W'($urandom());
            y = COORD_W'($urandom_range(MAX_SRC_HEIGHT, COORD_MAX));
            if ($urandom_range(0, 1))
               send_transaction(CMD_WRITE, x, y, PIX_W'($urandom()));
            else
               send_transaction(CMD_WRITE, y, x, PIX_W'($urandom()));
         end
      end
   endtask

   // Reset sizes: one-to-one mapping, corners and out-of-range coordinates
   task automatic test_identity_extremes();
      set_idling(0, 0);
      send_transaction(CMD_WRITE, 0, 0, 24'h000000);
      send_transaction(CMD_WRITE, 511, 511, 24'hFFFFFF);
      send_transaction(CMD_WRITE, 511, 0, 24'hA5A5A5);
      send_transaction(CMD_WRITE, 0, 511, 24'h5A5A5A);
      send_transaction(CMD_WRITE, 512, 0, 24'h123456);
      send_transaction(CMD_WRITE, 0, COORD_MAX, 24'h654321);
      send_transaction(CMD_WRITE, COORD_MAX, COORD_MAX, 24'hFEDCBA);
      send_transaction(CMD_READ, 0, 0, 24'hFFFFFF);
      send_transaction(CMD_READ, 511, 511, 24'h000000);
      send_transaction(CMD_READ, 511, 0, 24'h000000);
      send_transaction(CMD_READ, 0, 511, 24'h000000);
      send_transaction(CMD_READ, COORD_MAX, COORD_MAX, 24'h000000);
      send_transaction(CMD_READ, 1024, 0, 24'h000000);
      send_transaction(CMD_READ, 0, COORD_MAX, 24'h000000);
   endtask

   // Zero sizes, oversize source, masked upper bits, upscaling overshoot
   task automatic test_size_registers();
      program_sizes(0, 0, 0, 0);
      send_transaction(CMD_WRITE, 0, 0, 24'h13579B);
      read_scaled(0, 0, 0);
      read_scaled(COORD_MAX, COORD_MAX, 0);
      read_scaled(1, 1023, 0);
      program_sizes(12'hFFF, 12'h600, 12'hFFF, 12'hFFF);
      read_scaled(COORD_MAX, COORD_MAX, 1);
      read_scaled(1234, 77, 1);
      program_sizes(3, 2, 2048, 2048);
      read_scaled(COORD_MAX, COORD_MAX, 1);
      read_scaled(0, COORD_MAX, 0);
   endtask

   task automatic test_random_scaling();
      int mode;
      int phase;
      for (mode = 0; mode < 3; mode++) begin
         case (mode)
            0:       set_idling(34, 72);
            1:       set_idling(72, 34);
            default: set_idling(0, 0);
         endcase
         for (phase = 0; phase < 3; phase++) begin
            case (mode * 3 + phase)
               0:       program_sizes(512, 512, 2048, 2048);
               1:       program_sizes(1, 1, 1, 1);
               2:       program_sizes(512, 1, 1, 2048);
               3:       program_sizes(16, 512, 2048, 1);
               default: program_sizes(pick_src_size(), pick_src_size(),
                                      pick_dst_size(), pick_dst_size());
            endcase
            run_scaling_phase(PHASE_ITEMS);
         end
      end
   endtask

   // Receiver holds off while the sender keeps pushing; after a drain, reads run with random receiver stalls
   task automatic test_receiver_holdoff();
      int i;
      set_idling(0, 0);
      program_sizes(7, 5, 30, 11);
      hold_request <= hold_request + 1;
      for (i = 0; i < 40; i++)
         read_scaled(COORD_W'($urandom_range(0, 29)), COORD_W'($urandom_range(0, 10)), 0);
      wait_for_idle();
      set_idling(0, 34);
      for (i = 0; i < 20; i++)
         read_scaled(COORD_W'($urandom()), COORD_W'($urandom()), 1);
   endtask

   // Receiver: long hold-off on request, random stalls otherwise
   always @(posedge clock) begin
      if (hold_request != hold_seen) begin
         hold_seen <= hold_request;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   // Compare each accepted response with the oldest owed pixel
   always @(posedge clock) begin : check_responses
      logic [PIX_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $error("pixel_out: expected none, actual %06h", rsp_pixel_out);
            mismatch_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_pixel_out !== want) begin
               $error("pixel_out: expected %06h, actual %06h", want, rsp_pixel_out);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int wait_cycles;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_identity_extremes();
      test_size_registers();
      test_random_scaling();
      test_receiver_holdoff();
      req_valid <= 1'b0;
      wait_cycles = 0;
      while (pending_pixels.size() != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_pixels.size() != 0) begin
         $error("pixel_out: %0d responses never arrived", pending_pixels.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
